FILE: rtl/core/hsort_pkg.sv
package hsort_pkg;

  localparam int DEF_MAX_RECORDS = 64;

  localparam int SIZE_W = 48;
  localparam int TAG_W  = 16;
  localparam int TIME_W = 32;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] mtime;
  } rec_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BLD_INIT,
    ST_BLD_RD,
    ST_BLD_V,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_EXT_RD,
    ST_EXT_SW,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic rd_a_en;
    logic rd_b_en;
    logic wr_en;
  } ram_ctl_t;

endpackage

FILE: rtl/core/hsort_in_if.sv
interface hsort_in_if import hsort_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] file_size;
  logic [TAG_W-1:0]  file_tag;
  logic [TIME_W-1:0] mod_time;
  logic              last_in;

  modport source (output valid, file_size, file_tag, mod_time, last_in, input ready);
  modport sink   (input valid, file_size, file_tag, mod_time, last_in, output ready);
endinterface

FILE: rtl/core/hsort_out_if.sv
interface hsort_out_if import hsort_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] sorted_size;
  logic [TAG_W-1:0]  sorted_tag;
  logic [TIME_W-1:0] sorted_time;
  logic              overflowed;
  logic              last_out;

  modport source (output valid, sorted_size, sorted_tag, sorted_time, overflowed, last_out,
                  input ready);
  modport sink   (input valid, sorted_size, sorted_tag, sorted_time, overflowed, last_out,
                  output ready);
endinterface

FILE: rtl/core/hsort_ram.sv
module hsort_ram import hsort_pkg::*; #(
  parameter int DEPTH = DEF_MAX_RECORDS,
  parameter int AW    = $clog2(DEF_MAX_RECORDS)
) (
  input  logic          clk,
  input  ram_ctl_t      ctl,
  input  logic [AW-1:0] wr_addr,
  input  rec_t          wr_data,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output rec_t          rd_data_a,
  output rec_t          rd_data_b
);

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_a_en) begin
      rd_data_a <= mem[rd_addr_a];
    end
    if (ctl.rd_b_en) begin
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

FILE: rtl/core/heap_sort_by_size.sv
// Heap sort of file records by size.
// Input channel in_ch: one record per item (file_size key, file_tag, mod_time),
// last_in closes the set. Records are written into a record memory while the
// block is loading, one item per cycle. Records past MAX_RECORDS are dropped and
// the set is flagged as overflowed.
// After the last item the block sorts in place with a max-heap (build, then
// repeated extract of the root), then streams the records on out_ch in
// ascending size, overflowed on each and last_out on the final one.
// Sequencing: each heap level of a sift is a child read (ST_SIFT_RD), then a
// compare and write back (ST_SIFT_CMP) through the single write port of the
// record memory. A build step first reads its interior node (ST_BLD_RD,
// ST_BLD_V) and an extract step first swaps root and tail (ST_EXT_RD,
// ST_EXT_SW); each then sifts the value down L levels (at most log2 of the set
// size) plus a final compare. Emit reads each result (ST_OUT_RD, ST_OUT_LD) and
// holds it in ST_OUT_WAIT; a stalled result simply holds on out_ch. in_ch is not
// ready from the last item until the final result is taken.
// Reset clears the record count, the overflow flag and the controller; the
// record memory is not cleared, only entries of the current set are used.
module heap_sort_by_size import hsort_pkg::*; #(
  parameter int MAX_RECORDS = DEF_MAX_RECORDS
) (
  input  logic               clk,
  input  logic               rst,
  hsort_in_if.sink           in_ch,
  hsort_out_if.source        out_ch
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int XW = CW + 1;
  localparam logic [CW-1:0] CAP = CW'(MAX_RECORDS);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] TWO = CW'(2);

  state_t state, state_next;

  logic [CW-1:0] count;
  logic          ovf;
  logic [CW-1:0] len;
  logic [CW-1:0] k;
  logic [AW-1:0] node;
  logic          extract;
  rec_t          v;
  rec_t          out_rec;
  logic          out_ovf;
  logic          out_last;

  ram_ctl_t      ram_ctl;
  logic [AW-1:0] wr_addr;
  rec_t          wr_data;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  rec_t          rd_data_a;
  rec_t          rd_data_b;

  logic          in_acc;
  logic          out_acc;
  logic          store_ok;
  rec_t          in_rec;
  logic [XW-1:0] lc;
  logic [XW-1:0] rc;
  logic          big_l;
  logic          big_r;
  logic          sift_done;
  rec_t          big_val;
  rec_t          child;
  logic [XW-1:0] child_idx;
  logic [CW-1:0] k_dec;

  hsort_ram #(.DEPTH(MAX_RECORDS), .AW(AW)) u_ram (
    .clk       (clk),
    .ctl       (ram_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign store_ok = count < CAP;
  assign in_rec   = '{size: in_ch.file_size, tag: in_ch.file_tag, mtime: in_ch.mod_time};
  assign k_dec    = k - ONE;

  // Children of the sift node; the held value v stands in for the node itself.
  assign lc = XW'({node, 1'b0}) | XW'(1);
  assign rc = lc + XW'(1);

  always_comb begin
    big_l     = (lc < XW'(len)) && (rd_data_a.size > v.size);
    big_val   = big_l ? rd_data_a : v;
    big_r     = (rc < XW'(len)) && (rd_data_b.size > big_val.size);
    sift_done = !big_l && !big_r;
    child     = big_r ? rd_data_b : rd_data_a;
    child_idx = big_r ? rc : lc;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:     if (in_acc && in_ch.last_in) state_next = ST_BLD_INIT;
      ST_BLD_INIT: state_next = (count < TWO) ? ST_OUT_RD : ST_BLD_RD;
      ST_BLD_RD:   state_next = ST_BLD_V;
      ST_BLD_V:    state_next = ST_SIFT_RD;
      ST_SIFT_RD:  state_next = ST_SIFT_CMP;
      ST_SIFT_CMP: begin
        if (!sift_done) begin
          state_next = ST_SIFT_RD;
        end else if (!extract) begin
          state_next = (k == ONE) ? ST_EXT_RD : ST_BLD_RD;
        end else begin
          state_next = (k == ONE) ? ST_OUT_RD : ST_EXT_RD;
        end
      end
      ST_EXT_RD:   state_next = ST_EXT_SW;
      ST_EXT_SW:   state_next = ST_SIFT_RD;
      ST_OUT_RD:   state_next = ST_OUT_LD;
      ST_OUT_LD:   state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: if (out_acc) state_next = out_last ? ST_LOAD : ST_OUT_RD;
      default:     state_next = ST_LOAD;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    ram_ctl   = '0;
    wr_addr   = count[AW-1:0];
    wr_data   = in_rec;
    rd_addr_a = '0;
    rd_addr_b = '0;
    unique case (state)
      ST_LOAD: begin
        ram_ctl.wr_en = in_acc && store_ok;
      end
      ST_BLD_RD: begin
        ram_ctl.rd_a_en = 1'b1;
        rd_addr_a       = k_dec[AW-1:0];
      end
      ST_SIFT_RD: begin
        ram_ctl.rd_a_en = 1'b1;
        ram_ctl.rd_b_en = 1'b1;
        rd_addr_a       = lc[AW-1:0];
        rd_addr_b       = rc[AW-1:0];
      end
      ST_SIFT_CMP: begin
        ram_ctl.wr_en = 1'b1;
        wr_addr       = node;
        wr_data       = sift_done ? v : child;
      end
      ST_EXT_RD: begin
        ram_ctl.rd_a_en = 1'b1;
        ram_ctl.rd_b_en = 1'b1;
        rd_addr_b       = k[AW-1:0];
      end
      ST_EXT_SW: begin
        // old root goes to the tail, old tail becomes the sifted value
        ram_ctl.wr_en = 1'b1;
        wr_addr       = k[AW-1:0];
        wr_data       = rd_data_a;
      end
      ST_OUT_RD: begin
        ram_ctl.rd_a_en = 1'b1;
        rd_addr_a       = k[AW-1:0];
      end
      default: begin
        ram_ctl = '0;
      end
    endcase
  end

  assign in_ch.ready = (state == ST_LOAD);

  assign out_ch.valid       = (state == ST_OUT_WAIT);
  assign out_ch.sorted_size = out_rec.size;
  assign out_ch.sorted_tag  = out_rec.tag;
  assign out_ch.sorted_time = out_rec.mtime;
  assign out_ch.overflowed  = out_ovf;
  assign out_ch.last_out    = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      ovf     <= 1'b0;
      k       <= '0;
      extract <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (store_ok) begin
              count <= count + ONE;
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        ST_BLD_INIT: begin
          extract <= 1'b0;
          k       <= (count < TWO) ? '0 : (count >> 1);
        end
        ST_BLD_RD: begin
          node <= k_dec[AW-1:0];
          len  <= count;
        end
        ST_BLD_V: begin
          v <= rd_data_a;
        end
        ST_SIFT_CMP: begin
          if (!sift_done) begin
            node <= child_idx[AW-1:0];
          end else if (!extract) begin
            if (k == ONE) begin
              extract <= 1'b1;
              k       <= count - ONE;
            end else begin
              k <= k_dec;
            end
          end else begin
            k <= k_dec;
          end
        end
        ST_EXT_SW: begin
          v    <= rd_data_b;
          node <= '0;
          len  <= k;
        end
        ST_OUT_LD: begin
          out_rec  <= rd_data_a;
          out_ovf  <= ovf;
          out_last <= (k + ONE) == count;
        end
        ST_OUT_WAIT: begin
          if (out_acc) begin
            if (out_last) begin
              count <= '0;
              ovf   <= 1'b0;
              k     <= '0;
            end else begin
              k <= k + ONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hsort_pkg::*;

  localparam int CAP          = DEF_MAX_RECORDS;
  localparam int IDLE_LIMIT   = 20000;
  localparam int LONG_HOLD    = 600;
  localparam int TAIL_CYCLES  = 50;
  localparam int RANDOM_ITEMS = 450;
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  typedef enum int {KEYS_WIDE, KEYS_TIED, KEYS_EDGE} key_mix_t;

  typedef struct packed {
    rec_t rec;
    logic ovf;
    logic last;
  } sorted_rec_t;

  // Predicts the sorted stream of each set and checks what comes out.
  class size_sort_board;
    rec_t          held[$];
    bit            dropped;
    int unsigned   arrivals;
    sorted_rec_t   due_q[$];
    int unsigned   mismatches;
    int unsigned   checked;
    int unsigned   sets_closed;
    int unsigned   overflow_sets;
    int unsigned   largest_set;

    function int unsigned pending();
      return due_q.size();
    endfunction

    task report(input string what);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
    endtask

    function void swap_held(input int unsigned a, input int unsigned b);
      rec_t t;
      t = held[a];
      held[a] = held[b];
      held[b] = t;
    endfunction

    // strict compares, left child tested first: tie order must match exactly
    function void sift_held(input int unsigned len, input int unsigned root);
      int unsigned node, big, lc, rc;
      bit done;
      node = root;
      done = 1'b0;
      while (!done) begin
        big = node;
        lc = 2 * node + 1;
        rc = 2 * node + 2;
        if (lc < len && held[lc].size > held[big].size) big = lc;
        if (rc < len && held[rc].size > held[big].size) big = rc;
        if (big == node) begin
          done = 1'b1;
        end else begin
          swap_held(node, big);
          node = big;
        end
      end
    endfunction

    function void sort_by_size(input int unsigned len);
      int unsigned k;
      if (len < 2) return;
      for (k = len / 2; k > 0; k--) sift_held(len, k - 1);
      for (k = len - 1; k > 0; k--) begin
        swap_held(0, k);
        sift_held(k, 0);
      end
    endfunction

    function void note_record(input rec_t r, input logic last);
      sorted_rec_t s;
      int unsigned n;
      arrivals++;
      if (held.size() < CAP) held.push_back(r);
      else dropped = 1'b1;
      if (!last) return;
      n = held.size();
      sort_by_size(n);
      for (int unsigned k = 0; k < n; k++) begin
        s.rec  = held[k];
        s.ovf  = dropped;
        s.last = (k + 1 == n);
        due_q.push_back(s);
      end
      sets_closed++;
      if (dropped) overflow_sets++;
      if (arrivals > largest_set) largest_set = arrivals;
      held.delete();
      dropped = 1'b0;
      arrivals = 0;
    endfunction

    task check_result(input rec_t got, input logic ovf, input logic last);
      sorted_rec_t want;
      if (due_q.size() == 0) begin
        report($sformatf("result with nothing expected, size %0d tag %0h",
                         got.size, got.tag));
        return;
      end
      want = due_q.pop_front();
      checked++;
      if (got.size !== want.rec.size)
        report($sformatf("sorted_size %0d, want %0d", got.size, want.rec.size));
      if (got.tag !== want.rec.tag)
        report($sformatf("sorted_tag %0h, want %0h", got.tag, want.rec.tag));
      if (got.mtime !== want.rec.mtime)
        report($sformatf("sorted_time %0h, want %0h", got.mtime, want.rec.mtime));
      if (ovf !== want.ovf)
        report($sformatf("overflowed %b, want %b", ovf, want.ovf));
      if (last !== want.last)
        report($sformatf("last_out %b, want %b", last, want.last));
    endtask
  endclass

  logic clk;
  logic rst;

  hsort_in_if  in_ch ();
  hsort_out_if out_ch ();

  heap_sort_by_size #(.MAX_RECORDS(CAP)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  size_sort_board board;
  bit             hold_req;
  int unsigned    random_items;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic rec_t make_record(input key_mix_t mix);
    rec_t r;
    case (mix)
      KEYS_WIDE: r.size = {16'($urandom), 32'($urandom)};
      KEYS_TIED: r.size = SIZE_W'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 3))
          0: r.size = '0;
          1: r.size = SIZE_MAX;
          2: r.size = SIZE_MAX - SIZE_W'($urandom_range(0, 2));
          default: r.size = {16'($urandom), 32'($urandom)};
        endcase
      end
    endcase
    r.tag   = 16'($urandom);
    r.mtime = 32'($urandom);
    return r;
  endfunction

  function automatic rec_t fixed_record(input logic [SIZE_W-1:0] size,
                                        input logic [TAG_W-1:0] tag,
                                        input logic [TIME_W-1:0] mtime);
    rec_t r;
    r.size  = size;
    r.tag   = tag;
    r.mtime = mtime;
    return r;
  endfunction

  task automatic idle_input(input int unsigned cycles);
    if (cycles == 0) return;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic push_record(input rec_t r, input logic last);
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.file_size <= r.size;
    in_ch.file_tag  <= r.tag;
    in_ch.mod_time  <= r.mtime;
    in_ch.last_in   <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_set(input rec_t recs[$], input bit gappy);
    foreach (recs[k]) begin
      if (gappy) idle_input(pick_gap());
      push_record(recs[k], k == recs.size() - 1);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, eager stretches, and one-off long hold-offs.
  initial begin
    int unsigned hold_left, stall_left, span;
    bit eager;
    hold_left = 0;
    stall_left = 0;
    span = 0;
    eager = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (span == 0) begin
        eager = ($urandom_range(0, 2) == 0);
        span = 64;
      end
      span--;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!eager && $urandom_range(0, 2) == 0) begin
        stall_left = pick_gap();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor and watchdog: sample both channels at the rising edge.
  initial begin
    int unsigned idle_cycles;
    bit moved;
    rec_t got;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      moved = 1'b0;
      if (!rst && in_ch.valid && in_ch.ready) begin
        got.size  = in_ch.file_size;
        got.tag   = in_ch.file_tag;
        got.mtime = in_ch.mod_time;
        board.note_record(got, in_ch.last_in);
        moved = 1'b1;
      end
      if (!rst && out_ch.valid && out_ch.ready) begin
        got.size  = out_ch.sorted_size;
        got.tag   = out_ch.sorted_tag;
        got.mtime = out_ch.sorted_time;
        board.check_result(got, out_ch.overflowed, out_ch.last_out);
        moved = 1'b1;
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("[heap_sort_by_size] ERROR");
    $finish;
  end

  initial begin
    rec_t recs[$];
    int unsigned set_no, len;
    key_mix_t mix;
    bit gappy;

    board = new();
    hold_req = 1'b0;
    random_items = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.file_size = '0;
    in_ch.file_tag = '0;
    in_ch.mod_time = '0;
    in_ch.last_in = 1'b0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single-record sets at the field extremes
    recs = '{fixed_record(SIZE_MAX, 16'hFFFF, 32'hFFFF_FFFF)};
    send_set(recs, 1'b0);
    recs = '{fixed_record('0, 16'h0000, 32'h0000_0000)};
    send_set(recs, 1'b0);
    // ties in size mixed with both extremes
    recs = '{fixed_record(48'd7, 16'h0001, 32'h1111_0001),
             fixed_record(SIZE_MAX, 16'h0002, 32'h1111_0002),
             fixed_record('0, 16'h0003, 32'h1111_0003),
             fixed_record(48'd7, 16'h0004, 32'h1111_0004),
             fixed_record(48'd7, 16'h0005, 32'h1111_0005),
             fixed_record(SIZE_MAX, 16'h0006, 32'h1111_0006),
             fixed_record('0, 16'h0007, 32'h1111_0007),
             fixed_record(48'd7, 16'h0008, 32'h1111_0008)};
    send_set(recs, 1'b1);
    recs = '{fixed_record(48'h8000_0000_0000, 16'hA5A5, 32'h8000_0000),
             fixed_record(48'h7FFF_FFFF_FFFF, 16'h5A5A, 32'h7FFF_FFFF)};
    send_set(recs, 1'b0);
    recs = '{fixed_record(48'd1, 16'h0101, 32'd1),
             fixed_record(48'd2, 16'h0202, 32'd2),
             fixed_record(48'd3, 16'h0303, 32'd3)};
    send_set(recs, 1'b1);
    drain_results();

    set_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      // first sets: exactly full, last record dropped, several dropped
      case (set_no)
        0: len = CAP;
        1: len = CAP + 1;
        2: len = CAP + 4;
        default: begin
          case ($urandom_range(0, 19))
            0:          len = $urandom_range(CAP - 2, CAP);
            1:          len = $urandom_range(CAP + 1, CAP + 6);
            2, 3, 4:    len = $urandom_range(11, 40);
            default:    len = $urandom_range(1, 10);
          endcase
        end
      endcase
      mix = key_mix_t'($urandom_range(0, 2));
      gappy = ($urandom_range(0, 9) >= 3);
      recs.delete();
      repeat (len) recs.push_back(make_record(mix));

      // long receiver hold while the sender keeps pushing into a stalled input
      if (set_no == 4 || set_no == 25) hold_req = 1'b1;
      if (set_no % 9 == 8) drain_results();

      send_set(recs, gappy);
      random_items += len;
      set_no++;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d expected results never arrived", board.pending()));

    $display("covered %0d sets (%0d overflowed, largest %0d records), %0d random records",
             board.sets_closed, board.overflow_sets, board.largest_set, random_items);
    $display("checked %0d sorted records, %0d mismatches", board.checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("[heap_sort_by_size] OK");
    end else begin
      $display("[heap_sort_by_size] ERROR");
    end
    $finish;
  end

endmodule
